### rtl/asvm_pkg.sv
// ----------------------------------------------------------------------------
// asvm_pkg: shared types and constants of the additive voice mixer
// Holds the action codes, register indexes, sequencer states and the sine
// table function.
// ----------------------------------------------------------------------------
package asvm_pkg;

    localparam int VOICE_COUNT  = 16;
    localparam int VOICE_W      = $clog2(VOICE_COUNT);
    localparam int SINE_ENTRIES = 2048;
    localparam int SINE_W       = $clog2(SINE_ENTRIES);

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_HOLD   = 2'd1;
    localparam logic [1:0] ACT_RENDER = 2'd2;

    localparam logic [1:0] REG_LIMIT_LEVEL = 2'd0;
    localparam logic [1:0] REG_LIMIT_RECIP = 2'd1;
    localparam logic [1:0] REG_DECAY_HELD  = 2'd2;
    localparam logic [1:0] REG_DECAY_REL   = 2'd3;

    // Ceiling reciprocals 2^40/d of the Taylor denominators (2k)(2k+1); exact
    // floor division for every dividend below 2^32.
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        ((64'd1 << 40) + 64'd5)   / 64'd6,
        ((64'd1 << 40) + 64'd19)  / 64'd20,
        ((64'd1 << 40) + 64'd41)  / 64'd42,
        ((64'd1 << 40) + 64'd71)  / 64'd72,
        ((64'd1 << 40) + 64'd109) / 64'd110,
        ((64'd1 << 40) + 64'd155) / 64'd156,
        ((64'd1 << 40) + 64'd209) / 64'd210
    };

    // Sequencer states; one product per arithmetic state.
    typedef enum logic [3:0] {
        t_S_IDLE,
        t_S_RD,     // address voice stores
        t_S_LD,     // latch voice, issue sine reads
        t_S_H2,     // h * s2
        t_S_H3,     // h * s3
        t_S_HT,     // h * tri
        t_S_CLIP,   // clip, * reciprocal
        t_S_AMP,    // n * amplitude
        t_S_DEC,    // amplitude * decay, write back
        t_S_OUT
    } t_state;

    typedef struct packed {
        logic         en;
        logic [VOICE_W-1:0] voice;
    } t_wr_ctl;

    // Q30 Taylor sine, elaborated into the constant table.
    function automatic logic signed [15:0] sine_value(input int unsigned i);
        longint unsigned th, x2, term;
        longint sum, v;
        logic [79:0] prod;
        logic neg;
        th  = (longint'(i) * 64'd6746518852) >> SINE_W;
        neg = 1'b0;
        if (th > 64'd3373259426) begin
            th  = 64'd6746518852 - th;
            neg = 1'b1;
        end
        if (th > 64'd1686629713) begin
            th = 64'd3373259426 - th;
        end
        x2   = (th * th) >> 30;
        term = th;
        sum  = longint'(th);
        for (int k = 1; k <= 7; k++) begin
            prod = 80'((term * x2) >> 30) * 80'(TAYLOR_RECIP[k - 1]);
            term = 64'(prod >> 40);
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = longint'((longint'(sum) * 32767 + (64'd1 << 29)) >>> 30);
        if (v > 32767) begin
            v = 32767;
        end
        return neg ? 16'(-v) : 16'(v);
    endfunction

endpackage

### rtl/asvm_sine_rom.sv
// ----------------------------------------------------------------------------
// asvm_sine_rom: sine table with one registered read port
// One period in Q1.15.
// ----------------------------------------------------------------------------
module asvm_sine_rom (
    input  logic                            i_clk,
    input  logic [asvm_pkg::SINE_W-1:0]     i_addr,
    output logic signed [15:0]              o_data
);

    logic signed [15:0] r_rom [asvm_pkg::SINE_ENTRIES];
    logic signed [15:0] r_data;

    always_comb begin
        for (int i = 0; i < asvm_pkg::SINE_ENTRIES; i++) begin
            r_rom[i] = asvm_pkg::sine_value(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= r_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

### rtl/asvm_voice_store.sv
// ----------------------------------------------------------------------------
// asvm_voice_store: per-voice state registers
// Phase, step, weight, amplitude and held flag, written by start, hold and
// the render write-back.
// ----------------------------------------------------------------------------
module asvm_voice_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_hold,
    input  logic [asvm_pkg::VOICE_W-1:0]  i_slot,
    input  logic [31:0]                   i_step,
    input  logic [14:0]                   i_weight,
    input  logic [15:0]                   i_amp,
    input  logic                          i_held,
    input  asvm_pkg::t_wr_ctl             i_wb,
    input  logic [31:0]                   i_wb_phase,
    input  logic [23:0]                   i_wb_amp,
    input  logic [asvm_pkg::VOICE_W-1:0]  i_rd_voice,
    output logic [31:0]                   o_phase,
    output logic [31:0]                   o_step,
    output logic [14:0]                   o_weight,
    output logic [23:0]                   o_amp,
    output logic                          o_held
);

    logic [31:0] r_phase  [asvm_pkg::VOICE_COUNT];
    logic [31:0] r_step   [asvm_pkg::VOICE_COUNT];
    logic [14:0] r_weight [asvm_pkg::VOICE_COUNT];
    logic [23:0] r_amp    [asvm_pkg::VOICE_COUNT];
    logic [asvm_pkg::VOICE_COUNT-1:0] r_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < asvm_pkg::VOICE_COUNT; i++) begin
                r_phase[i]  <= '0;
                r_step[i]   <= '0;
                r_weight[i] <= '0;
                r_amp[i]    <= '0;
            end
            r_held <= '0;
        end else begin
            if (i_start) begin
                r_phase[i_slot]  <= '0;
                r_step[i_slot]   <= i_step;
                r_weight[i_slot] <= i_weight;
                r_amp[i_slot]    <= {i_amp, 8'd0};
            end
            if (i_start || i_hold) begin
                r_held[i_slot] <= i_held;
            end
            if (i_wb.en) begin
                r_phase[i_wb.voice] <= i_wb_phase;
                r_amp[i_wb.voice]   <= i_wb_amp;
            end
        end
    end

    assign o_phase  = r_phase[i_rd_voice];
    assign o_step   = r_step[i_rd_voice];
    assign o_weight = r_weight[i_rd_voice];
    assign o_amp    = r_amp[i_rd_voice];
    assign o_held   = r_held[i_rd_voice];

endmodule

### rtl/additive_synth_voice_mixer.sv
// ----------------------------------------------------------------------------
// additive_synth_voice_mixer: polyphonic additive oscillator bank
// Start, hold and render requests over a shared multiplier sequencer.
// ----------------------------------------------------------------------------
// Start and hold requests are written to the voice store when taken. A render
// request walks the voices one at a time through a single shared signed
// multiplier: per voice a store read, sine lookups, three harmonic products,
// clip and normalise, amplitude scale and decay, then an output state that
// registers the sample. Input stall stays high until the sample has been
// taken, so no request is taken while a render is in progress.
module additive_synth_voice_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_action,
    input  logic [3:0]         i_voice_slot,
    input  logic [31:0]        i_phase_step,
    input  logic [14:0]        i_harmonic_weight,
    input  logic [15:0]        i_start_amplitude,
    input  logic               i_key_held,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_mixed_sample,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);

    localparam int VW = asvm_pkg::VOICE_W;

    asvm_pkg::t_state r_state, n_state;
    logic [VW-1:0]    r_voice, n_voice;
    logic [14:0]      r_lim;
    logic [15:0]      r_recip;
    logic [23:0]      r_dheld, r_drel;

    logic [31:0] r_ph;
    logic [31:0] r_stp;
    logic [14:0] r_h;
    logic [23:0] r_amp;
    logic        r_held;
    logic signed [19:0] r_w, n_w;     // waveform accumulator
    logic signed [16:0] r_n, n_n;     // normalised voice sample
    logic signed [21:0] r_mix, n_mix;
    logic signed [15:0] r_out;
    logic        r_ovalid;

    // Sine lookups: s1, s2 and s3 addresses issued on successive cycles.
    logic [asvm_pkg::SINE_W-1:0] w_rom_addr;
    logic signed [15:0]          w_rom;

    logic        w_acc;
    logic        w_start, w_hold;
    logic [31:0] w_ph, w_stp;
    logic [14:0] w_h;
    logic [23:0] w_amp;
    logic        w_held;
    asvm_pkg::t_wr_ctl w_wb;

    // Shared multiplier.
    logic signed [24:0] w_ma;
    logic signed [24:0] w_mb;
    logic signed [49:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic signed [16:0] w_tri;
    logic [15:0]        w_f;
    logic [31:0]        w_ph3;
    logic signed [19:0] w_clip;
    logic signed [33:0] w_nfull;
    logic signed [22:0] w_mixs;

    assign w_acc   = i_valid && !o_stall;
    assign w_start = w_acc && i_action == asvm_pkg::ACT_START;
    assign w_hold  = w_acc && i_action == asvm_pkg::ACT_HOLD;
    assign o_stall = r_state != asvm_pkg::t_S_IDLE || r_ovalid;
    assign o_cfg_ready = 1'b1;

    assign w_wb.en    = r_state == asvm_pkg::t_S_DEC;
    assign w_wb.voice = r_voice;

    asvm_voice_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_hold     (w_hold),
        .i_slot     (i_voice_slot[VW-1:0]),
        .i_step     (i_phase_step),
        .i_weight   (i_harmonic_weight),
        .i_amp      (i_start_amplitude),
        .i_held     (i_key_held),
        .i_wb       (w_wb),
        .i_wb_phase (r_ph + r_stp),
        .i_wb_amp   (w_prod[47:24]),
        .i_rd_voice (r_voice),
        .o_phase    (w_ph),
        .o_step     (w_stp),
        .o_weight   (w_h),
        .o_amp      (w_amp),
        .o_held     (w_held)
    );

    asvm_sine_rom u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom)
    );

    // Triangle at four times the phase from the top bits of 4*phase.
    assign w_ph3 = r_ph + {r_ph[30:0], 1'b0};
    assign w_f   = r_ph[29:14];
    assign w_tri = w_f[15] ? 17'(19'sd2 * $signed({3'b000, w_f}) - 19'sd98304)
                           : 17'(19'sd32768 - 19'sd2 * $signed({3'b000, w_f}));

    // Index = top bits of the harmonic phase.
    always_comb begin
        case (r_state)
            asvm_pkg::t_S_RD: w_rom_addr = w_ph[31 -: asvm_pkg::SINE_W];
            asvm_pkg::t_S_LD: w_rom_addr = w_ph[30 -: asvm_pkg::SINE_W];
            asvm_pkg::t_S_H2: w_rom_addr = w_ph3[31 -: asvm_pkg::SINE_W];
            default:          w_rom_addr = r_ph[31 -: asvm_pkg::SINE_W];
        endcase
    end

    assign w_clip  = (r_w > $signed({5'd0, r_lim})) ? $signed({5'd0, r_lim})
                   : (r_w < -$signed({5'd0, r_lim})) ? -$signed({5'd0, r_lim}) : r_w;
    assign w_nfull = w_prod[45:12];
    assign w_mixs  = {r_mix[21], r_mix} + 23'(w_prod >>> 25);

    always_comb begin
        n_state = r_state;
        n_voice = r_voice;
        n_w     = r_w;
        n_n     = r_n;
        n_mix   = r_mix;
        w_ma    = '0;
        w_mb    = '0;
        case (r_state)
            asvm_pkg::t_S_IDLE: begin
                if (w_acc && i_action == asvm_pkg::ACT_RENDER) begin
                    n_state = asvm_pkg::t_S_RD;
                    n_voice = '0;
                    n_mix   = '0;
                end
            end
            asvm_pkg::t_S_RD: n_state = asvm_pkg::t_S_LD;
            asvm_pkg::t_S_LD: begin
                // w_rom is s1 here
                n_w     = 20'(w_rom);
                n_state = asvm_pkg::t_S_H2;
            end
            asvm_pkg::t_S_H2: begin
                // w_rom is s2; subtract h*s2
                w_ma    = 25'($signed({1'b0, r_h}));
                w_mb    = 25'(w_rom);
                n_w     = r_w - 20'(w_prod >>> 15);
                n_state = asvm_pkg::t_S_H3;
            end
            asvm_pkg::t_S_H3: begin
                // w_rom is s3; add h*s3
                w_ma    = 25'($signed({1'b0, r_h}));
                w_mb    = 25'(w_rom);
                n_w     = r_w + 20'(w_prod >>> 15);
                n_state = asvm_pkg::t_S_HT;
            end
            asvm_pkg::t_S_HT: begin
                w_ma    = 25'($signed({1'b0, r_h}));
                w_mb    = 25'(w_tri);
                n_w     = r_w - 20'(w_prod >>> 16);
                n_state = asvm_pkg::t_S_CLIP;
            end
            asvm_pkg::t_S_CLIP: begin
                w_ma = 25'(w_clip);
                w_mb = 25'($signed({1'b0, r_recip}));
                if (w_nfull > 34'sd32767) begin
                    n_n = 17'sd32767;
                end else if (w_nfull < -34'sd32767) begin
                    n_n = -17'sd32767;
                end else begin
                    n_n = 17'(w_nfull);
                end
                n_state = asvm_pkg::t_S_AMP;
            end
            asvm_pkg::t_S_AMP: begin
                // Scale by the amplitude and add into the mix.
                w_ma    = 25'(r_n);
                w_mb    = 25'($signed({1'b0, r_amp}));
                n_mix   = w_mixs[21:0];
                n_state = asvm_pkg::t_S_DEC;
            end
            asvm_pkg::t_S_DEC: begin
                n_state = (r_voice == VW'(asvm_pkg::VOICE_COUNT - 1))
                          ? asvm_pkg::t_S_OUT : asvm_pkg::t_S_RD;
                n_voice = r_voice + 1'b1;
                w_ma    = 25'($signed({1'b0, r_amp}));
                w_mb    = 25'($signed({1'b0, r_held ? r_dheld : r_drel}));
            end
            asvm_pkg::t_S_OUT: n_state = asvm_pkg::t_S_IDLE;
            default:           n_state = asvm_pkg::t_S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= asvm_pkg::t_S_IDLE;
            r_voice  <= '0;
            r_ovalid <= 1'b0;
            r_lim    <= 15'd16384;
            r_recip  <= 16'd8192;
            r_dheld  <= 24'd16776880;
            r_drel   <= 24'd16760439;
            r_mix    <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_mix   <= n_mix;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    asvm_pkg::REG_LIMIT_LEVEL: r_lim   <= i_cfg_data[14:0];
                    asvm_pkg::REG_LIMIT_RECIP: r_recip <= i_cfg_data[15:0];
                    asvm_pkg::REG_DECAY_HELD:  r_dheld <= i_cfg_data;
                    asvm_pkg::REG_DECAY_REL:   r_drel  <= i_cfg_data;
                    default:                   r_lim   <= r_lim;
                endcase
            end
            if (r_state == asvm_pkg::t_S_OUT) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        r_n <= n_n;
        if (r_state == asvm_pkg::t_S_LD) begin
            r_ph   <= w_ph;
            r_stp  <= w_stp;
            r_h    <= w_h;
            r_amp  <= w_amp;
            r_held <= w_held;
        end
        if (r_state == asvm_pkg::t_S_OUT) begin
            if (r_mix > 22'sd32767) begin
                r_out <= 16'sd32767;
            end else if (r_mix < -22'sd32767) begin
                r_out <= -16'sd32767;
            end else begin
                r_out <= 16'(r_mix);
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_mixed_sample = r_out;

endmodule

### bench/tb_additive_synth_voice_mixer.sv
// ----------------------------------------------------------------------------
// tb_additive_synth_voice_mixer: self-checking bench for the voice mixer
// Drives start, hold and render requests with random gaps, predicts each
// frame from a private model of the voice bank and compares every sample.
// ----------------------------------------------------------------------------
module tb_additive_synth_voice_mixer;

    // Private model of the voice bank and the frame queue it fills.
    class frame_scoreboard;
        logic [31:0]        phase [asvm_pkg::VOICE_COUNT];
        logic [31:0]        step [asvm_pkg::VOICE_COUNT];
        logic [14:0]        weight [asvm_pkg::VOICE_COUNT];
        logic [23:0]        amp [asvm_pkg::VOICE_COUNT];
        logic               held [asvm_pkg::VOICE_COUNT];
        logic signed [15:0] sine_tab [asvm_pkg::SINE_ENTRIES];
        logic [23:0]        regs [4];
        logic signed [15:0] frames [$];
        int                 frame_count;

        function new();
            for (int i = 0; i < asvm_pkg::SINE_ENTRIES; i++) begin
                sine_tab[i] = asvm_pkg::sine_value(i);
            end
            regs[asvm_pkg::REG_LIMIT_LEVEL] = 24'd16384;
            regs[asvm_pkg::REG_LIMIT_RECIP] = 24'd8192;
            regs[asvm_pkg::REG_DECAY_HELD]  = 24'd16776880;
            regs[asvm_pkg::REG_DECAY_REL]   = 24'd16760439;
            for (int v = 0; v < asvm_pkg::VOICE_COUNT; v++) begin
                phase[v] = 0; step[v] = 0; weight[v] = 0; amp[v] = 0; held[v] = 0;
            end
            frame_count = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                asvm_pkg::REG_LIMIT_LEVEL: regs[idx] = {9'd0, val[14:0]};
                asvm_pkg::REG_LIMIT_RECIP: regs[idx] = {8'd0, val[15:0]};
                default:                   regs[idx] = val;
            endcase
        endfunction

        function longint sine_at(logic [31:0] ph);
            return longint'(sine_tab[ph[31:32-asvm_pkg::SINE_W]]);
        endfunction

        // >>> on a signed longint floors, as the block's arithmetic does.
        function longint shaped_wave(int v);
            logic [31:0] p, p4;
            longint h, tri_v, w, lim, n, f;
            p     = phase[v];
            p4    = p * 4;
            h     = longint'(weight[v]);
            f     = longint'(p4[31:16]);
            tri_v = (f < 32768) ? (32768 - 2 * f) : (2 * f - 98304);
            w     = sine_at(p) - ((h * sine_at(p * 2)) >>> 15)
                  + ((h * sine_at(p * 3)) >>> 15) - ((h * tri_v) >>> 16);
            lim   = longint'(regs[asvm_pkg::REG_LIMIT_LEVEL]);
            if (w > lim) w = lim;
            if (w < -lim) w = -lim;
            n = (w * longint'(regs[asvm_pkg::REG_LIMIT_RECIP])) >>> 12;
            if (n > 32767) n = 32767;
            if (n < -32767) n = -32767;
            return n;
        endfunction

        // Note an accepted request; a render queues one expected sample.
        function void note_request(logic [1:0] act, logic [3:0] slot, logic [31:0] stp,
                                   logic [14:0] wt, logic [15:0] sa, logic kh);
            longint mix;
            longint unsigned prod;
            if (act == asvm_pkg::ACT_START) begin
                phase[slot] = 0; step[slot] = stp; weight[slot] = wt;
                amp[slot] = {sa, 8'd0}; held[slot] = kh;
            end else if (act == asvm_pkg::ACT_HOLD) begin
                held[slot] = kh;
            end else if (act == asvm_pkg::ACT_RENDER) begin
                mix = 0;
                for (int v = 0; v < asvm_pkg::VOICE_COUNT; v++) begin
                    mix += (shaped_wave(v) * longint'(amp[v])) >>> 25;
                    phase[v] = phase[v] + step[v];
                    prod = longint'(amp[v]) *
                           longint'(held[v] ? regs[asvm_pkg::REG_DECAY_HELD]
                                            : regs[asvm_pkg::REG_DECAY_REL]);
                    amp[v] = 24'(prod >> 24);
                end
                if (mix > 32767) mix = 32767;
                if (mix < -32767) mix = -32767;
                frames.push_back(16'(mix));
            end
        endfunction

        // Compare one output sample with the oldest expected one; 1 on mismatch.
        function bit check_sample(logic signed [15:0] got, output string msg);
            logic signed [15:0] want;
            frame_count++;
            if (frames.size() == 0) begin
                msg = $sformatf("sample %0d with no frame pending", got);
                return 1;
            end
            want = frames.pop_front();
            if (got !== want) begin
                msg = $sformatf("frame %0d: got %0d want %0d", frame_count, got, want);
                return 1;
            end
            return 0;
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall;
    logic [1:0]         i_action;
    logic [3:0]         i_voice_slot;
    logic [31:0]        i_phase_step;
    logic [14:0]        i_harmonic_weight;
    logic [15:0]        i_start_amplitude;
    logic               i_key_held;
    logic               o_valid, i_stall;
    logic signed [15:0] o_mixed_sample;
    logic               i_cfg_valid, o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;

    frame_scoreboard sb;
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  calm = 1'b0;       // stretch with no idling on either side
    bit  stall_en = 1'b0;
    int  n_start, n_hold, n_render;

    localparam int WATCHDOG_LIMIT = 20000;

    additive_synth_voice_mixer uut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    task automatic report(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Receiver: stall at random, check every sample taken.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sb.check_sample(o_mixed_sample, msg)) report(msg);
        end
        i_stall <= stall_en && !calm && ($urandom_range(99) < 36);
    end

    // Watchdog: count cycles in which no request or sample moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d frames pending", sb.frames.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Send one request, with a random gap first, and hold it until taken.
    // Valid stays high after the accepting edge unless a gap or a wait follows.
    task automatic send_request(logic [1:0] act, logic [3:0] slot, logic [31:0] stp,
                                logic [14:0] wt, logic [15:0] sa, logic kh);
        if (!calm && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 36) @(posedge i_clk);
        end
        i_valid <= 1'b1; i_action <= act; i_voice_slot <= slot; i_phase_step <= stp;
        i_harmonic_weight <= wt; i_start_amplitude <= sa; i_key_held <= kh;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(act, slot, stp, wt, sa, kh);
        case (act)
            asvm_pkg::ACT_START:  n_start++;
            asvm_pkg::ACT_HOLD:   n_hold++;
            asvm_pkg::ACT_RENDER: n_render++;
            default: ;
        endcase
    endtask

    // Drop valid, drain outstanding frames, then let the clock run on with valid low.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.frames.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 30) begin
            // Mostly audible pitches, sometimes any step or a silent slot.
            send_request(asvm_pkg::ACT_START, 4'($urandom),
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(200000000),
                         15'($urandom), ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom),
                         1'($urandom));
        end else if (r < 45) begin
            send_request(asvm_pkg::ACT_HOLD, 4'($urandom), $urandom, 15'($urandom),
                         16'($urandom), 1'($urandom));
        end else if (r < 48) begin
            send_request(2'd3, 4'($urandom), $urandom, 15'($urandom), 16'($urandom),
                         1'($urandom));
        end else begin
            send_request(asvm_pkg::ACT_RENDER, 4'($urandom), $urandom, 15'($urandom),
                         16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        n_start = 0; n_hold = 0; n_render = 0;
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_action <= asvm_pkg::ACT_RENDER;
        i_voice_slot <= 0; i_phase_step <= 0; i_harmonic_weight <= 0;
        i_start_amplitude <= 0; i_key_held <= 0; i_cfg_valid <= 1'b0; i_cfg_index <= 0;
        i_cfg_data <= 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        stall_en = 1'b1;
        @(posedge i_clk);

        // Directed: render with all voices silent, then field extremes.
        send_request(asvm_pkg::ACT_RENDER, 0, 0, 0, 0, 0);
        send_request(asvm_pkg::ACT_START, 4'd0, 32'd0, 15'd0, 16'hFFFF, 1'b1);
        send_request(asvm_pkg::ACT_START, 4'd15, 32'hFFFF_FFFF, 15'h7FFF, 16'hFFFF, 1'b0);
        send_request(asvm_pkg::ACT_START, 4'd7, 32'd85000000, 15'h4000, 16'h8000, 1'b1);
        send_request(asvm_pkg::ACT_START, 4'd3, 32'd12345678, 15'd1, 16'd0, 1'b1);
        send_request(asvm_pkg::ACT_RENDER, 0, 0, 0, 0, 0);
        send_request(asvm_pkg::ACT_HOLD, 4'd7, 0, 0, 0, 1'b0);
        send_request(asvm_pkg::ACT_HOLD, 4'd0, 0, 0, 0, 1'b1);
        send_request(2'd3, 4'd5, 32'hFFFF_FFFF, 15'h7FFF, 16'hFFFF, 1'b1);
        repeat (4) send_request(asvm_pkg::ACT_RENDER, 0, 0, 0, 0, 0);
        for (int v = 1; v < 15; v += 2) begin
            send_request(asvm_pkg::ACT_START, 4'(v), 32'd40000000 * v, 15'h7FFF,
                         16'hFFFF, 1'b1);
        end
        send_request(asvm_pkg::ACT_RENDER, 0, 0, 0, 0, 0);
        send_request(asvm_pkg::ACT_RENDER, 0, 0, 0, 0, 0);

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'd32767);
                    write_reg(asvm_pkg::REG_LIMIT_RECIP, 24'd4096);
                    write_reg(asvm_pkg::REG_DECAY_HELD, 24'hFFFFFF);
                    write_reg(asvm_pkg::REG_DECAY_REL, 24'hFFFFFF);
                end
                1: begin
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'd1);
                    write_reg(asvm_pkg::REG_LIMIT_RECIP, 24'd65535);
                    write_reg(asvm_pkg::REG_DECAY_HELD, 24'd0);
                    write_reg(asvm_pkg::REG_DECAY_REL, 24'd0);
                end
                2: begin
                    // Clip level of zero silences every voice.
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'd0);
                    write_reg(asvm_pkg::REG_DECAY_HELD, 24'd16776880);
                    write_reg(asvm_pkg::REG_DECAY_REL, 24'd16760439);
                end
                3: begin
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'd4000);
                    write_reg(asvm_pkg::REG_LIMIT_RECIP, 24'd40000);
                    calm = 1'b1;
                end
                4: begin
                    calm = 1'b0;
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'($urandom_range(32767, 1)));
                    write_reg(asvm_pkg::REG_LIMIT_RECIP, 24'($urandom_range(65535, 4096)));
                    write_reg(asvm_pkg::REG_DECAY_HELD, 24'($urandom));
                    write_reg(asvm_pkg::REG_DECAY_REL, 24'($urandom));
                end
                default: begin
                    write_reg(asvm_pkg::REG_LIMIT_LEVEL, 24'd16384);
                    write_reg(asvm_pkg::REG_LIMIT_RECIP, 24'd8192);
                    write_reg(asvm_pkg::REG_DECAY_HELD, 24'd16776880);
                    write_reg(asvm_pkg::REG_DECAY_REL, 24'd16760439);
                end
            endcase
            repeat (65) random_request();
        end

        wait_idle();
        $display("Covered %0d starts, %0d key changes and %0d rendered frames",
                 n_start, n_hold, n_render);
        $display("across six register settings, including the clip and decay extremes.");
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
